[src/tts_pkg.sv]
// ============================================================================
// tts_pkg: shared types and constants of the timer table scheduler
// Command and result records, opcode and result codes, back-end states.
// ============================================================================
`default_nettype none

package tts_pkg;

    // Fixed widths of the request and result fields.
    localparam int ACTION_W    = 2;
    localparam int ID_W        = 4;
    localparam int IV_IN_W     = 24;
    localparam int NOW_W       = 48;

    // Defaults of the top-level parameters.
    localparam int SLOTS_DEF         = 16;
    localparam int INTERVAL_BITS_DEF = 24;

    // At most this many timers fire on one tick.
    localparam int MAX_FIRES   = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_FIRES + 1);

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH  = 2;

    typedef enum logic [ACTION_W-1:0] {
        OP_ADD     = 2'd0,
        OP_DELETE  = 2'd1,
        OP_RESTART = 2'd2,
        OP_TICK    = 2'd3
    } cmd_op_t;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_FIRED   = 2'd3
    } res_kind_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        cmd_op_t              op;
        logic [ID_W-1:0]      id;
        logic [IV_IN_W-1:0]   interval;
        logic                 once;
    } cmd_t;

    typedef struct packed {
        res_kind_t            kind;
        logic [ID_W-1:0]      slot_id;
        logic                 status;
        logic                 last;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ADD,
        BK_DELETE,
        BK_RST_RD,
        BK_RST_WR,
        BK_SCAN,
        BK_FIRE_RD,
        BK_FIRE_WR
    } bk_state_t;

endpackage

`default_nettype wire

[src/tts_front.sv]
// ============================================================================
// tts_front: request intake of the timer table scheduler
// Decodes each request into a command and holds it in a short queue.
// ============================================================================
`default_nettype none

module tts_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [tts_pkg::ACTION_W-1:0] action,
    input  wire logic [tts_pkg::ID_W-1:0]     timer_id,
    input  wire logic [tts_pkg::IV_IN_W-1:0]  interval_ticks,
    input  wire logic                        one_shot,
    output logic                             cmd_valid,
    input  wire logic                        cmd_take,
    output tts_pkg::cmd_t                    cmd
);
    import tts_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t               q_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    cmd_t               cmd_in;
    logic               push_ok;

    // Classify the raw action code; fields a command does not use pass along.
    always_comb
    begin
        cmd_in.id       = timer_id;
        cmd_in.interval = interval_ticks;
        cmd_in.once     = one_shot;
        case (action)
            OP_ADD:     cmd_in.op = OP_ADD;
            OP_DELETE:  cmd_in.op = OP_DELETE;
            OP_RESTART: cmd_in.op = OP_RESTART;
            default:    cmd_in.op = OP_TICK;
        endcase
    end

    assign full      = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign push_ok   = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_ok && !cmd_take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push_ok && cmd_take)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[src/tts_back.sv]
// ============================================================================
// tts_back: command execution of the timer table scheduler
// Owns the timer table, runs commands and tick scans, holds one result.
// ============================================================================
`default_nettype none

module tts_back #(
    parameter int SLOTS         = tts_pkg::SLOTS_DEF,
    parameter int INTERVAL_BITS = tts_pkg::INTERVAL_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    output logic              cmd_take,
    input  wire tts_pkg::cmd_t cmd,
    input  wire logic         res_pop,
    output logic              res_valid,
    output tts_pkg::res_t     res
);
    import tts_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > ID_W) ? CNT_W : ID_W;

    // Table storage: deadlines and periods live in single-port-read memories.
    logic [NOW_W-1:0]         dl_mem [SLOTS];
    logic [INTERVAL_BITS-1:0] pd_mem [SLOTS];

    bk_state_t                state_reg, state_next;
    cmd_t                     cmd_reg;
    logic [NOW_W-1:0]         now_reg;
    logic [SLOTS-1:0]         active_reg, once_reg, due_reg;
    logic [CNT_W-1:0]         scan_idx_reg;
    logic                     rd_vld_reg;
    logic [SLOT_W-1:0]        rd_idx_reg;
    logic [NOW_W-1:0]         rd_dl_reg;
    logic [INTERVAL_BITS-1:0] rd_pd_reg;
    logic                     best_vld_reg;
    logic [SLOT_W-1:0]        best_reg;
    logic [NOW_W-1:0]         best_dl_reg;
    logic                     mark_reg;
    logic [FIRE_CNT_W-1:0]    fire_cnt_reg;
    logic                     res_valid_reg;
    res_t                     res_reg;

    logic                     out_free;
    logic                     free_found;
    logic [SLOT_W-1:0]        free_slot;
    logic [SLOT_W-1:0]        id_slot;
    logic                     id_ok;
    logic                     due_j, cand, upd, scan_done, best_vld_nx;
    logic [SLOTS-1:0]         due_rest;
    logic                     fire_last;

    logic [SLOT_W-1:0]        rd_addr;
    logic                     rd_issue;
    logic                     dl_we, pd_we, act_set, act_clr, once_we, due_clr;
    logic [SLOT_W-1:0]        wr_slot;
    logic [NOW_W-1:0]         dl_wdata;
    logic                     emit;
    res_t                     res_next;
    logic                     tick_start, rescan;

    assign out_free = !res_valid_reg || res_pop;
    assign id_slot  = SLOT_W'(cmd_reg.id);
    assign id_ok    = (CMP_W'(cmd_reg.id) < CMP_W'(SLOTS)) && active_reg[id_slot];

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Scan evaluation on the deadline just read.
    always_comb
    begin
        due_j       = active_reg[rd_idx_reg] && (rd_dl_reg <= now_reg);
        cand        = mark_reg ? due_j : due_reg[rd_idx_reg];
        upd         = rd_vld_reg && cand && (!best_vld_reg || (rd_dl_reg < best_dl_reg));
        scan_done   = (state_reg == BK_SCAN) && rd_vld_reg
                      && (rd_idx_reg == SLOT_W'(SLOTS - 1));
        best_vld_nx = best_vld_reg || upd;
        due_rest    = due_reg & ~(SLOTS'(1) << best_reg);
        fire_last   = (due_rest == '0) || (fire_cnt_reg == FIRE_CNT_W'(MAX_FIRES - 1));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_ADD:     state_next = BK_ADD;
                        OP_DELETE:  state_next = BK_DELETE;
                        OP_RESTART: state_next = BK_RST_RD;
                        default:    state_next = BK_SCAN;
                    endcase
                end
            end
            BK_ADD, BK_DELETE, BK_RST_WR:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_RST_RD:  state_next = BK_RST_WR;
            BK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = best_vld_nx ? BK_FIRE_RD : BK_IDLE;
                end
            end
            BK_FIRE_RD: state_next = BK_FIRE_WR;
            BK_FIRE_WR:
            begin
                if (out_free)
                begin
                    state_next = fire_last ? BK_IDLE : BK_SCAN;
                end
            end
            default:    state_next = BK_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb
    begin
        cmd_take   = 1'b0;
        rd_addr    = id_slot;
        rd_issue   = 1'b0;
        dl_we      = 1'b0;
        pd_we      = 1'b0;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        once_we    = 1'b0;
        due_clr    = 1'b0;
        wr_slot    = id_slot;
        dl_wdata   = now_reg + NOW_W'(rd_pd_reg);
        emit       = 1'b0;
        res_next   = '{kind: KIND_ADD, slot_id: '0, status: STATUS_OK, last: 1'b1};
        tick_start = 1'b0;
        rescan     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_take   = cmd_valid;
                tick_start = cmd_valid && (cmd.op == OP_TICK);
            end
            BK_ADD:
            begin
                emit     = out_free;
                wr_slot  = free_slot;
                dl_wdata = now_reg + NOW_W'(INTERVAL_BITS'(cmd_reg.interval));
                res_next = '{kind: KIND_ADD,
                             slot_id: free_found ? ID_W'(free_slot) : '0,
                             status: free_found ? STATUS_OK : STATUS_FAIL,
                             last: 1'b1};
                if (out_free && free_found)
                begin
                    dl_we   = 1'b1;
                    pd_we   = 1'b1;
                    act_set = 1'b1;
                    once_we = 1'b1;
                end
            end
            BK_DELETE:
            begin
                emit     = out_free;
                act_clr  = out_free && id_ok;
                res_next = '{kind: KIND_DELETE, slot_id: cmd_reg.id,
                             status: id_ok ? STATUS_OK : STATUS_FAIL, last: 1'b1};
            end
            BK_RST_WR:
            begin
                emit     = out_free;
                dl_we    = out_free && id_ok;
                res_next = '{kind: KIND_RESTART, slot_id: cmd_reg.id,
                             status: id_ok ? STATUS_OK : STATUS_FAIL, last: 1'b1};
            end
            BK_SCAN:
            begin
                rd_addr  = scan_idx_reg[SLOT_W-1:0];
                rd_issue = (scan_idx_reg < CNT_W'(SLOTS));
            end
            BK_FIRE_RD:
            begin
                rd_addr  = best_reg;
            end
            BK_FIRE_WR:
            begin
                rd_addr  = best_reg;
                wr_slot  = best_reg;
                emit     = out_free;
                res_next = '{kind: KIND_FIRED, slot_id: ID_W'(best_reg),
                             status: STATUS_OK, last: fire_last};
                if (out_free)
                begin
                    due_clr = 1'b1;
                    rescan  = !fire_last;
                    if (once_reg[best_reg])
                    begin
                        act_clr = 1'b1;
                    end
                    else
                    begin
                        dl_we = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Table memories, registered read.
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[wr_slot] <= dl_wdata;
        end
        if (pd_we)
        begin
            pd_mem[wr_slot] <= INTERVAL_BITS'(cmd_reg.interval);
        end
        rd_dl_reg <= dl_mem[rd_addr];
        rd_pd_reg <= pd_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            now_reg       <= '0;
            active_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_issue;
            if (tick_start)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (act_set)
            begin
                active_reg[wr_slot] <= 1'b1;
            end
            if (act_clr)
            begin
                active_reg[wr_slot] <= 1'b0;
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        if (once_we)
        begin
            once_reg[wr_slot] <= cmd_reg.once;
        end
        if (emit)
        begin
            res_reg <= res_next;
        end
        if (tick_start)
        begin
            fire_cnt_reg <= '0;
        end
        else if (due_clr)
        begin
            fire_cnt_reg <= fire_cnt_reg + 1'b1;
        end
        if (tick_start || rescan)
        begin
            scan_idx_reg <= '0;
            best_vld_reg <= 1'b0;
            mark_reg     <= tick_start;
        end
        else if (state_reg == BK_SCAN)
        begin
            if (rd_issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (rd_vld_reg && mark_reg)
            begin
                due_reg[rd_idx_reg] <= due_j;
            end
            if (upd)
            begin
                best_vld_reg <= 1'b1;
                best_reg     <= rd_idx_reg;
                best_dl_reg  <= rd_dl_reg;
            end
            if (scan_done)
            begin
                mark_reg <= 1'b0;
            end
        end
        if (due_clr)
        begin
            due_reg[best_reg] <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[src/timer_table_scheduler_core.sv]
// ============================================================================
// timer_table_scheduler_core: table of one-shot and periodic software timers
// Adds, deletes and restarts timers and fires due timers on each tick.
// ============================================================================
//
// Channel   | Side   | Handshake           | Fields
// ----------+--------+---------------------+-------------------------------------
// request   | input  | push / full         | action, timer_id, interval_ticks,
//           |        |                     | one_shot
// result    | output | pop / empty         | kind, slot_id, status, last
//
// Flow: a request waits in a two-entry command queue until the idle back
// end takes it. Add and delete then run in one state; restart reads the
// period memory in one state and writes the new deadline in the next. A
// tick walks the deadline memory once to mark the due timers and find the
// earliest, and every fire reads and updates its slot and, unless it is
// the last fire of the tick, walks the memory again to find the next one.
// Each fire needs a new walk because the deadline memory has a single
// read port.
// Reset: asynchronous, active low. It clears the time count, all active
// flags, the command queue and the result register; the deadline and
// period memories keep no reset value and need no clearing pass.
// Stalls: while the result register is full and not popped, the back end
// holds in any state that writes a result; requests still collect in the
// command queue until it fills and raises full.
//
`default_nettype none

module timer_table_scheduler_core #(
    parameter int SLOTS         = tts_pkg::SLOTS_DEF,
    parameter int INTERVAL_BITS = tts_pkg::INTERVAL_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Request side.
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [tts_pkg::ACTION_W-1:0] action,
    input  wire logic [tts_pkg::ID_W-1:0]     timer_id,
    input  wire logic [tts_pkg::IV_IN_W-1:0]  interval_ticks,
    input  wire logic                         one_shot,
    // Result side.
    output logic                              empty,
    input  wire logic                         pop,
    output logic [1:0]                        kind,
    output logic [tts_pkg::ID_W-1:0]          slot_id,
    output logic                              status,
    output logic                              last
);
    import tts_pkg::*;

    cmd_t   cmd;
    logic   cmd_valid;
    logic   cmd_take;
    logic   res_valid;
    res_t   res;
    logic   res_pop;

    // The front end decodes requests and buffers them so that a new request
    // can be taken while the back end is busy with a tick scan or waits on
    // an unread result.
    tts_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .timer_id       (timer_id),
        .interval_ticks (interval_ticks),
        .one_shot       (one_shot),
        .cmd_valid      (cmd_valid),
        .cmd_take       (cmd_take),
        .cmd            (cmd)
    );

    // The back end owns the timer table and the time count and produces the
    // results into a single output register.
    tts_back #(
        .SLOTS         (SLOTS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .res_pop   (res_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty   = !res_valid;
    assign res_pop = pop && res_valid;
    assign kind    = res.kind;
    assign slot_id = res.slot_id;
    assign status  = res.status;
    assign last    = res.last;

    // Only a tick can cause more than one result, so a result that is not
    // the final one of its request is always a fired timer.
    a_not_last_is_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> (kind == KIND_FIRED))
        else $error("non-final result is not a fired timer");

    // Fired timers never carry a failure status.
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_FIRED) |-> (status == STATUS_OK))
        else $error("fired timer with failure status");

    // After a non-final result is taken, the next result shown belongs to
    // the same tick and is a fired timer again.
    a_series_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=> (empty || kind == KIND_FIRED))
        else $error("tick result series broken");

endmodule

`default_nettype wire

[sim/tb_timer_table_scheduler_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_timer_table_scheduler_core: self-checking bench of the timer table
// A short table of directed requests, then weighted random requests. A local
// copy of the timer table predicts every result. Results are checked in order
// as the receiver pops them.
// ============================================================================

module tb_timer_table_scheduler_core;

    import tts_pkg::*;

    localparam int NUM_SLOTS    = SLOTS_DEF;
    localparam int RANDOM_COUNT = 450;
    // A tick that fires every slot, plus the receiver stall on its final
    // result, is the slowest request still in flight, and this settle time
    // covers it.
    localparam int SETTLE_CYCLES = 400;

    // One directed stimulus row. Rows with typed set carry their own expected
    // result. All other rows are checked against the predictor.
    typedef struct {
        cmd_op_t         op;
        logic [ID_W-1:0] id;
        logic [23:0]     iv;
        logic            once;
        bit              typed;
        res_t            want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic            push = 1'b0;
    logic            full;
    logic [1:0]      action = 2'd0;
    logic [ID_W-1:0] timer_id = '0;
    logic [23:0]     interval_ticks = '0;
    logic            one_shot = 1'b0;
    logic            empty;
    logic            pop = 1'b0;
    logic [1:0]      kind;
    logic [ID_W-1:0] slot_id;
    logic            status;
    logic            last;

    // Private copy of the timer table that the predictor keeps.
    logic [NOW_W-1:0] tick_count = '0;
    logic [NOW_W-1:0] due_at [NUM_SLOTS];
    logic [23:0]      reload [NUM_SLOTS];
    bit               armed [NUM_SLOTS];
    bit               single [NUM_SLOTS];

    res_t      step_results [$];
    res_t      pending_results [$];
    stim_row_t directed_rows [$];

    int mismatch_count = 0;
    int burst_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    timer_table_scheduler_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .timer_id       (timer_id),
        .interval_ticks (interval_ticks),
        .one_shot       (one_shot),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .slot_id        (slot_id),
        .status         (status),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run ends here if the block stops answering. The bound is several
    // times the slowest correct run: every request a full tick, every result
    // held by the longest receiver stall, every request after the longest gap.
    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Predicts the results of one accepted request and updates the local
    // table. The results land in step_results, oldest first.
    task automatic advance_timer_table(input cmd_op_t op, input logic [ID_W-1:0] id,
                                       input logic [23:0] iv, input logic once_bit);
        bit   due_now [NUM_SLOTS];
        int   fired [$];
        int   best;
        bit   placed;
        res_t r;

        step_results.delete();
        placed = 1'b0;
        case (op)
            OP_ADD:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!placed && !armed[i])
                    begin
                        armed[i]  = 1'b1;
                        reload[i] = iv;
                        single[i] = once_bit;
                        due_at[i] = tick_count + NOW_W'(iv);
                        r = '{KIND_ADD, ID_W'(i), STATUS_OK, 1'b1};
                        placed = 1'b1;
                    end
                end
                // With no free slot the add reports slot zero and a full table.
                if (!placed)
                begin
                    r = '{KIND_ADD, '0, STATUS_FAIL, 1'b1};
                end
                step_results.insert(step_results.size(), r);
            end
            OP_DELETE, OP_RESTART:
            begin
                if (!armed[id])
                begin
                    r = '{res_kind_t'(op), id, STATUS_FAIL, 1'b1};
                end
                else
                begin
                    if (op == OP_DELETE)
                    begin
                        armed[id] = 1'b0;
                    end
                    else
                    begin
                        due_at[id] = tick_count + NOW_W'(reload[id]);
                    end
                    r = '{res_kind_t'(op), id, STATUS_OK, 1'b1};
                end
                step_results.insert(step_results.size(), r);
            end
            default:
            begin
                // The count moves first; then every timer due at the new count
                // fires, earliest deadline first and lower slot on a tie.
                tick_count = tick_count + 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    due_now[i] = armed[i] && (due_at[i] <= tick_count);
                end
                while (fired.size() < MAX_FIRES)
                begin
                    best = -1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (due_now[i] && (best < 0 || due_at[i] < due_at[best]))
                        begin
                            best = i;
                        end
                    end
                    if (best < 0)
                    begin
                        break;
                    end
                    due_now[best] = 1'b0;
                    if (single[best])
                    begin
                        armed[best] = 1'b0;
                    end
                    else
                    begin
                        due_at[best] = tick_count + NOW_W'(reload[best]);
                    end
                    fired.insert(fired.size(), best);
                end
                // Only the final fire of the tick is marked last; a quiet tick
                // yields nothing at all.
                foreach (fired[k])
                begin
                    r = '{KIND_FIRED, ID_W'(fired[k]), STATUS_OK, k == fired.size() - 1};
                    step_results.insert(step_results.size(), r);
                end
            end
        endcase
    endtask

    // Holds push low between bursts. A gap of zero starts the next burst
    // without dropping push, so back-to-back requests also occur.
    task automatic pace_sender();
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Offers one request and waits until it is accepted. Expected results are
    // queued at the edge of acceptance.
    task automatic send_request(input cmd_op_t op, input logic [ID_W-1:0] id,
                                input logic [23:0] iv, input logic once_bit,
                                input bit typed, input res_t want);
        push           <= 1'b1;
        action         <= op;
        timer_id       <= id;
        interval_ticks <= iv;
        one_shot       <= once_bit;
        do
            @(posedge clk);
        while (full !== 1'b0);
        advance_timer_table(op, id, iv, once_bit);
        if (typed)
        begin
            pending_results.insert(pending_results.size(), want);
        end
        else
        begin
            foreach (step_results[k])
            begin
                pending_results.insert(pending_results.size(), step_results[k]);
            end
        end
    endtask

    function automatic stim_row_t stim_row(input cmd_op_t op, input int id, input int iv,
                                           input bit once_bit, input bit typed,
                                           input res_kind_t k, input int slot,
                                           input logic st);
        stim_row_t s;

        s.op    = op;
        s.id    = ID_W'(id);
        s.iv    = 24'(iv);
        s.once  = once_bit;
        s.typed = typed;
        s.want  = '{k, ID_W'(slot), st, 1'b1};
        return s;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(input stim_row_t s);
        directed_rows.insert(directed_rows.size(), s);
    endtask

    // Receiver: the stall pattern is redrawn at random at regular intervals from
    // popping at once, popping at random, and popping on a sparse regular schedule.
    always @(posedge clk)
    begin
        res_t want;

        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d slot %0d status %0d",
                                          kind, slot_id, status));
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind || slot_id !== want.slot_id ||
                    status !== want.status || last !== want.last)
                begin
                    report_mismatch($sformatf(
                        "got kind %0d slot %0d status %0d last %0d, want %0d %0d %0d %0d",
                        kind, slot_id, status, last,
                        want.kind, want.slot_id, want.status, want.last));
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0)
        begin
            rx_mode = $urandom_range(0, 2);
        end
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            default: pop <= (rx_cycle % 8 == 0);
        endcase
    end

    initial
    begin
        cmd_op_t    op;
        logic [3:0] id;
        logic [23:0] iv;
        int         pick;
        int         live [$];

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            due_at[i] = '0;
            reload[i] = '0;
            armed[i]  = 1'b0;
            single[i] = 1'b0;
        end

        // Directed requests. Typed results: failures on an empty table, the
        // first two adds after reset, and the add that finds the table full.
        add_row(stim_row(OP_TICK,    0, 0, 0, 0, KIND_FIRED, 0, STATUS_OK));
        add_row(stim_row(OP_DELETE,  0, 0, 0, 1, KIND_DELETE, 0, STATUS_FAIL));
        add_row(stim_row(OP_RESTART, 15, 0, 1, 1, KIND_RESTART, 15, STATUS_FAIL));
        // A zero interval fires on every tick; the longest interval never comes due.
        add_row(stim_row(OP_ADD,     15, 0, 0, 1, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 24'hFFFFFF, 1, 1, KIND_ADD, 1, STATUS_OK));
        add_row(stim_row(OP_TICK,    0, 0, 0, 0, KIND_FIRED, 0, STATUS_OK));
        add_row(stim_row(OP_TICK,    15, 24'hFFFFFF, 1, 0, KIND_FIRED, 0, STATUS_OK));
        // Fill the rest of the table with timers that fall due close together.
        add_row(stim_row(OP_ADD,     0, 1, 1, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 2, 0, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 3, 1, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 0, 1, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 5, 0, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 1, 0, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 2, 1, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 24'h800000, 0, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 4, 1, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 1, 1, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 3, 0, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 2, 0, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 0, 0, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 6, 1, 0, KIND_ADD, 0, STATUS_OK));
        add_row(stim_row(OP_ADD,     0, 7, 0, 1, KIND_ADD, 0, STATUS_FAIL));
        // Many timers due on one tick, then commands on live slots.
        add_row(stim_row(OP_TICK,    0, 0, 0, 0, KIND_FIRED, 0, STATUS_OK));
        add_row(stim_row(OP_RESTART, 1, 0, 0, 0, KIND_RESTART, 1, STATUS_OK));
        add_row(stim_row(OP_DELETE,  15, 0, 0, 0, KIND_DELETE, 15, STATUS_OK));

        // Reset is held low from the start and released on a rising edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            pace_sender();
            send_request(directed_rows[r].op, directed_rows[r].id, directed_rows[r].iv,
                         directed_rows[r].once, directed_rows[r].typed,
                         directed_rows[r].want);
        end

        // Random requests. Most intervals are short so that timers keep
        // firing; a few use the full 24-bit range. Deletes and restarts
        // mostly address live slots so that they take effect.
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                op = OP_ADD;
            end
            else if (pick < 40)
            begin
                op = OP_DELETE;
            end
            else if (pick < 55)
            begin
                op = OP_RESTART;
            end
            else
            begin
                op = OP_TICK;
            end
            live.delete();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (armed[i])
                begin
                    live.insert(live.size(), i);
                end
            end
            if (live.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                id = ID_W'(live[$urandom_range(0, live.size() - 1)]);
            end
            else
            begin
                id = ID_W'($urandom_range(0, NUM_SLOTS - 1));
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                iv = 24'($urandom_range(0, 6));
            end
            else if (pick < 9)
            begin
                iv = 24'($urandom_range(0, 40));
            end
            else
            begin
                iv = 24'($urandom());
            end
            pace_sender();
            send_request(op, id, iv, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
        push <= 1'b0;

        // Drain: wait for every expected result, then give a tick that is
        // still scanning time to show any result it should not produce.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
